// ===== rtl/twrl_pkg.sv =====
// ----------------------------------------------------------------------------
// twrl_pkg
// Types, constants and helpers shared by the two-level windowed rate limiter.
// ----------------------------------------------------------------------------
package twrl_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned TimeWidth  = 48;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 24;

  // Request kinds
  localparam logic [1:0] ReqTick    = 2'd0;
  localparam logic [1:0] ReqCreate  = 2'd1;
  localparam logic [1:0] ReqAcquire = 2'd2;

  // Create status codes
  localparam logic [1:0] CrtCreated = 2'd0;
  localparam logic [1:0] CrtExists  = 2'd1;
  localparam logic [1:0] CrtFull    = 2'd2;

  // Register indexes
  localparam logic [CfgAddrW-1:0] RegAcctSecLimit = 3'd0;
  localparam logic [CfgAddrW-1:0] RegAcctSecWin   = 3'd1;
  localparam logic [CfgAddrW-1:0] RegAcctMinLimit = 3'd2;
  localparam logic [CfgAddrW-1:0] RegAcctMinWin   = 3'd3;
  localparam logic [CfgAddrW-1:0] RegRefresh      = 3'd4;
  localparam logic [CfgAddrW-1:0] RegMaxEntries   = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] ip_addr;
    logic [15:0] credit_count;
    logic [15:0] sec_limit;
    logic [7:0]  sec_window_s;
    logic [15:0] min_limit;
    logic [7:0]  min_window_min;
  } req_t;

  typedef struct packed {
    logic [1:0] reply_kind;
    logic       account_granted;
    logic       addr_granted;
    logic [1:0] create_status;
  } rsp_t;

  // Window check request/answer between sequencer and the shared unit
  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] limit;
    logic [23:0] window;
  } win_op_t;

endpackage

// ===== rtl/twrl_win_unit.sv =====
// ----------------------------------------------------------------------------
// twrl_win_unit
// Shared window unit: expiry test on the time distance and credit compare.
// ----------------------------------------------------------------------------
module twrl_win_unit #(
  parameter int unsigned TimeWidth = twrl_pkg::TimeWidth
) (
  input  logic [TimeWidth-1:0] now_i,
  input  logic [TimeWidth-1:0] last_i,
  input  logic [23:0]          window_i,
  input  logic [15:0]          a_i,
  input  logic [15:0]          b_i,
  output logic                 expired_o,
  output logic                 ge_o
);
  logic [TimeWidth-1:0] age;

  // Distance wraps modulo the clock width.
  assign age       = now_i - last_i;
  assign expired_o = (age >= TimeWidth'(window_i));
  assign ge_o      = (a_i >= b_i);
endmodule

// ===== rtl/twrl_table.sv =====
// ----------------------------------------------------------------------------
// twrl_table
// Per-address limiter store: registered read, single write port.
// ----------------------------------------------------------------------------
module twrl_table #(
  parameter int unsigned TableDepth = twrl_pkg::TableDepth,
  parameter int unsigned TimeWidth  = twrl_pkg::TimeWidth,
  localparam int unsigned IdxW      = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  logic                 clk_i,
  input  logic [IdxW-1:0]      rd_idx_i,
  input  logic                 we_i,
  input  logic [IdxW-1:0]      wr_idx_i,
  input  logic [31:0]          wr_key_i,
  input  logic [15:0]          wr_sl_i,
  input  logic [23:0]          wr_sw_i,
  input  logic [15:0]          wr_ml_i,
  input  logic [23:0]          wr_mw_i,
  input  logic [15:0]          wr_sr_i,
  input  logic [15:0]          wr_mr_i,
  input  logic [TimeWidth-1:0] wr_st_i,
  input  logic [TimeWidth-1:0] wr_mt_i,
  output logic [31:0]          rd_key_o,
  output logic [15:0]          rd_sl_o,
  output logic [23:0]          rd_sw_o,
  output logic [15:0]          rd_ml_o,
  output logic [23:0]          rd_mw_o,
  output logic [15:0]          rd_sr_o,
  output logic [15:0]          rd_mr_o,
  output logic [TimeWidth-1:0] rd_st_o,
  output logic [TimeWidth-1:0] rd_mt_o
);
  localparam int unsigned EntW = 32 + 16 + 24 + 16 + 24 + 16 + 16 + 2*TimeWidth;
  logic [EntW-1:0] mem_q [TableDepth];
  logic [EntW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_idx_i] <= {wr_key_i, wr_sl_i, wr_sw_i, wr_ml_i, wr_mw_i,
                          wr_sr_i, wr_mr_i, wr_st_i, wr_mt_i};
    end
    rd_q <= mem_q[rd_idx_i];
  end

  assign {rd_key_o, rd_sl_o, rd_sw_o, rd_ml_o, rd_mw_o,
          rd_sr_o, rd_mr_o, rd_st_o, rd_mt_o} = rd_q;
endmodule

// ===== rtl/two_level_windowed_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// two_level_windowed_rate_limiter
// Fixed-window credit limiter: one account level and a table of per-address
// limiters, each with a short and a long window.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// req      in   req_valid_i/stall_o  twrl_pkg::req_t
// rsp      out  rsp_valid_o/stall_i  twrl_pkg::rsp_t
// cfg      in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// A transfer is taken only in idle. A tick without a refresh goes from the
// account state to the decide and output states. A refresh tick checks both
// account windows, then walks every entry through read, wait, short, long
// and write, then decides and outputs. Create and acquire walk the table the
// same way for the key compare.
// The entry-by-entry walk follows from the one table read port and the shared unit.
// Reset is asynchronous and active low; the table needs no clearing pass.
// A result waits in the output register while rsp_stall_i is high, and
// req_stall_o stays high until it has gone.
// ----------------------------------------------------------------------------
module two_level_windowed_rate_limiter #(
  parameter int unsigned TableDepth = twrl_pkg::TableDepth,
  parameter int unsigned TimeWidth  = twrl_pkg::TimeWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_stall_o,
  input  twrl_pkg::req_t                req_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_stall_i,
  output twrl_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [twrl_pkg::CfgAddrW-1:0] cfg_idx_i,
  input  logic [twrl_pkg::CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StAcct   = 9'b000000010,
    StRead   = 9'b000000100,
    StWait   = 9'b000001000,
    StSec    = 9'b000010000,
    StMin    = 9'b000100000,
    StDecide = 9'b001000000,
    StWrite  = 9'b010000000,
    StOut    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [15:0] acct_sl_q;
  logic [23:0] acct_sw_q;
  logic [15:0] acct_ml_q;
  logic [23:0] acct_mw_q;
  logic [15:0] period_q;
  logic [4:0]  max_q;

  // Account state
  logic [TimeWidth-1:0] now_q;
  logic [15:0]          cdown_q;
  logic [15:0]          acct_sr_q, acct_mr_q;
  logic [TimeWidth-1:0] acct_st_q, acct_mt_q;
  logic [TableDepth-1:0] valid_q;
  logic [CntW-1:0]      used_q;

  // Item in flight
  twrl_pkg::req_t req_q;
  logic [CntW-1:0] idx_q;
  logic            found_q;
  logic [IdxW-1:0] hit_q;
  logic            refresh_q;
  logic            acc_q;
  logic            step_q;     // 0 account short, 1 account long
  logic [15:0]     sr_q, mr_q;
  logic [TimeWidth-1:0] st_q, mt_q;
  twrl_pkg::rsp_t  rsp_q;
  logic            rsp_valid_q;

  // Snapshot of the hit entry, taken as the scan passes it.
  logic [15:0]          hit_sr, hit_mr;
  logic [TimeWidth-1:0] hit_st, hit_mt;

  // Table ports
  logic [IdxW-1:0] rd_idx, wr_idx;
  logic            tbl_we;
  logic [31:0]     t_key;
  logic [15:0]     t_sl, t_ml, t_sr, t_mr;
  logic [23:0]     t_sw, t_mw;
  logic [TimeWidth-1:0] t_st, t_mt;
  logic [23:0]     new_sw, new_mw;
  logic            is_create;
  logic [31:0]     w_key;
  logic [15:0]     w_sl, w_ml;
  logic [23:0]     w_sw, w_mw;

  // Shared unit
  logic [TimeWidth-1:0] u_last;
  logic [23:0]          u_win;
  logic [15:0]          u_a, u_b;
  logic                 u_exp, u_ge;

  logic [CntW-1:0] cap;
  logic [16:0]     sum_s, sum_m;
  logic            accept;
  logic [15:0]     n;
  logic            addr_ok;
  logic [1:0]      crt_status;

  assign n      = req_q.credit_count;
  assign accept = req_valid_i && !req_stall_o;
  assign req_stall_o = (state_q != StIdle) || rsp_valid_q;
  // Once the scan is done, point the read port at the hit entry.
  assign rd_idx = (idx_q == CntW'(TableDepth)) ? hit_q : idx_q[IdxW-1:0];
  assign new_sw = 24'(req_q.sec_window_s) * 24'd1000;
  assign new_mw = 24'(req_q.min_window_min) * 24'd60000;
  assign cap    = (32'(max_q) > 32'(TableDepth)) ? CntW'(TableDepth) : CntW'(max_q);
  assign sum_s  = {1'b0, acct_sr_q} + {1'b0, n};
  assign sum_m  = {1'b0, acct_mr_q} + {1'b0, n};
  assign addr_ok = found_q && (hit_sr >= n) && (hit_mr >= n);
  assign crt_status = (req_q.req_type != twrl_pkg::ReqCreate) ? twrl_pkg::CrtCreated :
                      found_q          ? twrl_pkg::CrtExists :
                      (used_q >= cap)  ? twrl_pkg::CrtFull : twrl_pkg::CrtCreated;

  // Create writes the new limits; other writes keep the entry's own.
  assign is_create = (req_q.req_type == twrl_pkg::ReqCreate);
  assign w_key = is_create ? req_q.ip_addr   : t_key;
  assign w_sl  = is_create ? req_q.sec_limit : t_sl;
  assign w_sw  = is_create ? new_sw          : t_sw;
  assign w_ml  = is_create ? req_q.min_limit : t_ml;
  assign w_mw  = is_create ? new_mw          : t_mw;

  twrl_table #(.TableDepth(TableDepth), .TimeWidth(TimeWidth)) u_table (
    .clk_i, .rd_idx_i(rd_idx), .we_i(tbl_we), .wr_idx_i(wr_idx),
    .wr_key_i(w_key), .wr_sl_i(w_sl), .wr_sw_i(w_sw),
    .wr_ml_i(w_ml), .wr_mw_i(w_mw), .wr_sr_i(sr_q),
    .wr_mr_i(mr_q), .wr_st_i(st_q), .wr_mt_i(mt_q),
    .rd_key_o(t_key), .rd_sl_o(t_sl), .rd_sw_o(t_sw), .rd_ml_o(t_ml),
    .rd_mw_o(t_mw), .rd_sr_o(t_sr), .rd_mr_o(t_mr), .rd_st_o(t_st),
    .rd_mt_o(t_mt)
  );

  // Route operands to the one shared unit by state.
  always_comb begin
    u_last = acct_st_q;
    u_win  = acct_sw_q;
    u_a    = 16'd0;
    u_b    = n;
    unique case (state_q)
      StAcct: begin
        if (refresh_q) begin
          u_last = step_q ? acct_mt_q : acct_st_q;
          u_win  = step_q ? acct_mw_q : acct_sw_q;
        end else begin
          u_a = step_q ? acct_mr_q : acct_sr_q;
        end
      end
      StSec: begin
        u_last = t_st;
        u_win  = t_sw;
        u_a    = t_sr;
      end
      StMin: begin
        u_last = mt_q;
        u_win  = t_mw;
        u_a    = mr_q;
      end
      default: ;
    endcase
  end

  twrl_win_unit #(.TimeWidth(TimeWidth)) u_unit (
    .now_i(now_q), .last_i(u_last), .window_i(u_win), .a_i(u_a), .b_i(u_b),
    .expired_o(u_exp), .ge_o(u_ge)
  );

  always_comb begin
    state_d = state_q;
    tbl_we  = 1'b0;
    wr_idx  = hit_q;
    unique case (state_q)
      StIdle:   if (accept) state_d = StAcct;
      StAcct: begin
        if (req_q.req_type == twrl_pkg::ReqTick && !refresh_q) begin
          state_d = StDecide;
        end else if (step_q || (!refresh_q && req_q.req_type != twrl_pkg::ReqAcquire)) begin
          state_d = StRead;
        end
      end
      StRead:   state_d = (idx_q == CntW'(TableDepth)) ? StDecide : StWait;
      StWait:   state_d = StSec;
      StSec:    state_d = StMin;
      StMin:    state_d = StWrite;
      StWrite: begin
        tbl_we  = refresh_q && valid_q[idx_q[IdxW-1:0]];
        wr_idx  = idx_q[IdxW-1:0];
        state_d = StRead;
      end
      StDecide: state_d = StOut;
      StOut: begin
        tbl_we  = (req_q.req_type == twrl_pkg::ReqCreate && !found_q && used_q < cap)
                  || (req_q.req_type == twrl_pkg::ReqAcquire && acc_q && found_q);
        wr_idx  = (req_q.req_type == twrl_pkg::ReqCreate) ? used_q[IdxW-1:0] : hit_q;
        state_d = StIdle;
      end
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      acct_sl_q   <= 16'd10;
      acct_sw_q   <= 24'd1000;
      acct_ml_q   <= 16'd100;
      acct_mw_q   <= 24'd60000;
      period_q    <= 16'd1;
      max_q       <= 5'd16;
      now_q       <= '0;
      cdown_q     <= 16'd1;
      acct_sr_q   <= 16'd10;
      acct_mr_q   <= 16'd100;
      acct_st_q   <= '0;
      acct_mt_q   <= '0;
      valid_q     <= '0;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
      refresh_q   <= 1'b0;
      step_q      <= 1'b0;
      acc_q       <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
      req_q       <= '0;
      hit_q       <= '0;
      rsp_q       <= '0;
      sr_q        <= '0;
      mr_q        <= '0;
      st_q        <= '0;
      mt_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          twrl_pkg::RegAcctSecLimit: acct_sl_q <= cfg_data_i[15:0];
          twrl_pkg::RegAcctSecWin:   acct_sw_q <= cfg_data_i;
          twrl_pkg::RegAcctMinLimit: acct_ml_q <= cfg_data_i[15:0];
          twrl_pkg::RegAcctMinWin:   acct_mw_q <= cfg_data_i;
          twrl_pkg::RegRefresh:      period_q  <= cfg_data_i[15:0];
          twrl_pkg::RegMaxEntries:   max_q     <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (rsp_valid_q && !rsp_stall_i) rsp_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (accept) begin
          req_q   <= req_i;
          step_q  <= 1'b0;
          acc_q   <= 1'b0;
          found_q <= 1'b0;
          idx_q   <= '0;
          refresh_q <= (req_i.req_type == twrl_pkg::ReqTick) && (cdown_q <= 16'd1);
          if (req_i.req_type == twrl_pkg::ReqTick) begin
            // Advance the clock; run a refresh when the countdown runs out.
            now_q <= now_q + 1'b1;
            if (cdown_q <= 16'd1) begin
              cdown_q   <= (period_q == 16'd0) ? 16'd1 : period_q;
            end else begin
              cdown_q <= cdown_q - 16'd1;
            end
          end
        end
        StAcct: begin
          step_q <= 1'b1;
          if (refresh_q && u_exp) begin
            if (step_q) begin
              acct_mr_q <= acct_ml_q;
              acct_mt_q <= now_q;
            end else begin
              acct_sr_q <= acct_sl_q;
              acct_st_q <= now_q;
            end
          end
          if (!refresh_q && req_q.req_type == twrl_pkg::ReqAcquire) begin
            // Collect both window compares for the account take.
            if (!step_q) acc_q <= u_ge;
            else if (acc_q && u_ge) begin
              acct_sr_q <= acct_sr_q - n;
              acct_mr_q <= acct_mr_q - n;
            end else acc_q <= 1'b0;
          end
          if (req_q.req_type == twrl_pkg::ReqTick && !refresh_q) idx_q <= CntW'(TableDepth);
        end
        StWait: ;
        StSec: begin
          sr_q <= (refresh_q && u_exp) ? t_sl : t_sr;
          st_q <= (refresh_q && u_exp) ? now_q : t_st;
          mr_q <= t_mr;
          mt_q <= t_mt;
          if (!refresh_q) begin
            // Key compare for the scan; first hit wins.
            if (valid_q[idx_q[IdxW-1:0]] && t_key == req_q.ip_addr && !found_q) begin
              found_q <= 1'b1;
              hit_q   <= idx_q[IdxW-1:0];
            end
          end
        end
        StMin: begin
          if (refresh_q && u_exp) begin
            mr_q <= t_ml;
            mt_q <= now_q;
          end
          if (!refresh_q && found_q && hit_q == idx_q[IdxW-1:0]
              && req_q.req_type == twrl_pkg::ReqAcquire) begin
            // Hold the hit entry's windows for the address take.
            sr_q <= sr_q;
          end
        end
        StWrite: idx_q <= idx_q + 1'b1;
        StDecide: begin
          rsp_q.reply_kind      <= req_q.req_type;
          rsp_q.account_granted <= (req_q.req_type == twrl_pkg::ReqAcquire) && acc_q;
          rsp_q.addr_granted    <= (req_q.req_type == twrl_pkg::ReqAcquire) && acc_q
                                   && addr_ok;
          rsp_q.create_status   <= crt_status;
          if (req_q.req_type == twrl_pkg::ReqCreate) begin
            sr_q <= req_q.sec_limit;
            mr_q <= req_q.min_limit;
            st_q <= now_q;
            mt_q <= now_q;
          end
          if (req_q.req_type == twrl_pkg::ReqAcquire) begin
            if (acc_q) begin
              if (addr_ok) begin
                sr_q <= hit_sr - n;
                mr_q <= hit_mr - n;
                st_q <= hit_st;
                mt_q <= hit_mt;
              end else begin
                // Refund per window, only where the sum stays within the limit.
                if (sum_s <= {1'b0, acct_sl_q}) acct_sr_q <= sum_s[15:0];
                if (sum_m <= {1'b0, acct_ml_q}) acct_mr_q <= sum_m[15:0];
                found_q <= 1'b0;
              end
            end
          end
        end
        StOut: begin
          rsp_valid_q <= 1'b1;
          if (req_q.req_type == twrl_pkg::ReqCreate && !found_q && used_q < cap) begin
            valid_q[used_q[IdxW-1:0]] <= 1'b1;
            used_q <= used_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StSec && !refresh_q && valid_q[idx_q[IdxW-1:0]]
        && t_key == req_q.ip_addr && !found_q) begin
      hit_sr <= t_sr;
      hit_mr <= t_mr;
      hit_st <= t_st;
      hit_mt <= t_mt;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> req_stall_o) else $error("accepted while busy");
  a_used_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(TableDepth)) else $error("table count overflow");
  a_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |=> rsp_valid_o) else $error("result lost");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_stall_i) |=> rsp_valid_o && $stable(rsp_o))
    else $error("stalled result changed");
endmodule

// ===== bench/tb_two_level_windowed_rate_limiter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_level_windowed_rate_limiter
// Self-checking bench for the two-level windowed rate limiter. It keeps its
// own account and address-table credit predictor and works out one expected
// reply per accepted request. It runs several register settings, extremes
// among them, under varied sender gaps and receiver stalls. Each reply is
// compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_two_level_windowed_rate_limiter;
  import twrl_pkg::*;

  localparam int unsigned CyclesLimit = 600000;
  localparam int unsigned DrainCycles = 200;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                req_valid_i = 1'b0;
  logic                req_stall_o;
  req_t                req_i = '0;
  logic                rsp_valid_o;
  logic                rsp_stall_i = 1'b0;
  rsp_t                rsp_o;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  two_level_windowed_rate_limiter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Requests waiting to be driven, replies waiting to be seen
  req_t pending_reqs[$];
  rsp_t expected_replies[$];
  int   errors = 0;
  int   send_idle_pct;
  int   rcv_stall_pct;
  logic req_taken = 1'b0;
  int unsigned cycles = 0;

  // Register copies, as the block sees them
  logic [15:0] acct_sec_lim, acct_min_lim, refresh_period;
  logic [23:0] acct_sec_win, acct_min_win;
  logic [4:0]  table_cap_reg;

  // Limiter state
  logic [TimeWidth-1:0] now_ms;
  logic [15:0]          countdown;
  logic [15:0]          acct_sec_rem, acct_min_rem;
  logic [TimeWidth-1:0] acct_sec_last, acct_min_last;
  logic                 ent_valid [TableDepth];
  logic [31:0]          ent_key [TableDepth];
  logic [15:0]          ent_sec_lim [TableDepth];
  logic [15:0]          ent_min_lim [TableDepth];
  logic [23:0]          ent_sec_win [TableDepth];
  logic [23:0]          ent_min_win [TableDepth];
  logic [15:0]          ent_sec_rem [TableDepth];
  logic [15:0]          ent_min_rem [TableDepth];
  logic [TimeWidth-1:0] ent_sec_last [TableDepth];
  logic [TimeWidth-1:0] ent_min_last [TableDepth];
  int                   ent_used;

  // Refill a window whose time has run out; the subtraction wraps by width
  function automatic void refill(inout logic [15:0] rem,
                                 inout logic [TimeWidth-1:0] last,
                                 input logic [15:0] lim, input logic [23:0] win);
    logic [TimeWidth-1:0] age;
    age = now_ms - last;
    if (age >= TimeWidth'(win)) begin
      rem  = lim;
      last = now_ms;
    end
  endfunction

  function automatic int find_slot(logic [31:0] key);
    for (int i = 0; i < TableDepth; i++) begin
      if (ent_valid[i] && ent_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Work out the reply to one request and advance the limiter state
  function automatic rsp_t limiter_reply(req_t r);
    rsp_t res;
    int   slot;
    int   cap;
    res = '0;
    res.reply_kind = r.req_type;
    case (r.req_type)
      ReqTick: begin
        now_ms = now_ms + 1'b1;
        if (countdown <= 16'd1) begin
          refill(acct_sec_rem, acct_sec_last, acct_sec_lim, acct_sec_win);
          refill(acct_min_rem, acct_min_last, acct_min_lim, acct_min_win);
          for (int i = 0; i < TableDepth; i++) begin
            if (ent_valid[i]) begin
              refill(ent_sec_rem[i], ent_sec_last[i], ent_sec_lim[i], ent_sec_win[i]);
              refill(ent_min_rem[i], ent_min_last[i], ent_min_lim[i], ent_min_win[i]);
            end
          end
          countdown = (refresh_period == 16'd0) ? 16'd1 : refresh_period;
        end else begin
          countdown = countdown - 1'b1;
        end
      end
      ReqCreate: begin
        cap = (table_cap_reg > TableDepth) ? int'(TableDepth) : int'(table_cap_reg);
        if (find_slot(r.ip_addr) >= 0) begin
          res.create_status = CrtExists;
        end else if (ent_used >= cap) begin
          res.create_status = CrtFull;
        end else begin
          ent_valid[ent_used]    = 1'b1;
          ent_key[ent_used]      = r.ip_addr;
          ent_sec_lim[ent_used]  = r.sec_limit;
          ent_min_lim[ent_used]  = r.min_limit;
          ent_sec_win[ent_used]  = 24'(32'(r.sec_window_s) * 32'd1000);
          ent_min_win[ent_used]  = 24'(32'(r.min_window_min) * 32'd60000);
          ent_sec_rem[ent_used]  = r.sec_limit;
          ent_min_rem[ent_used]  = r.min_limit;
          ent_sec_last[ent_used] = now_ms;
          ent_min_last[ent_used] = now_ms;
          ent_used++;
          res.create_status = CrtCreated;
        end
      end
      ReqAcquire: begin
        if (acct_sec_rem >= r.credit_count && acct_min_rem >= r.credit_count) begin
          acct_sec_rem = acct_sec_rem - r.credit_count;
          acct_min_rem = acct_min_rem - r.credit_count;
          res.account_granted = 1'b1;
          slot = find_slot(r.ip_addr);
          if (slot >= 0 && ent_sec_rem[slot] >= r.credit_count &&
              ent_min_rem[slot] >= r.credit_count) begin
            ent_sec_rem[slot] = ent_sec_rem[slot] - r.credit_count;
            ent_min_rem[slot] = ent_min_rem[slot] - r.credit_count;
            res.addr_granted = 1'b1;
          end else begin
            // Hand the account credits back, window by window, only where the sum stays within the limit
            if ({1'b0, acct_sec_rem} + r.credit_count <= {1'b0, acct_sec_lim})
              acct_sec_rem = acct_sec_rem + r.credit_count;
            if ({1'b0, acct_min_rem} + r.credit_count <= {1'b0, acct_min_lim})
              acct_min_rem = acct_min_rem + r.credit_count;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Write one register while the block is idle, and mirror it
  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      RegAcctSecLimit: acct_sec_lim   = val[15:0];
      RegAcctSecWin:   acct_sec_win   = val;
      RegAcctMinLimit: acct_min_lim   = val[15:0];
      RegAcctMinWin:   acct_min_win   = val;
      RegRefresh:      refresh_period = val[15:0];
      RegMaxEntries:   table_cap_reg  = val[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(int sl, int sw, int ml, int mw, int rp, int me);
    write_reg(RegAcctSecLimit, CfgDataW'(sl));
    write_reg(RegAcctSecWin,   CfgDataW'(sw));
    write_reg(RegAcctMinLimit, CfgDataW'(ml));
    write_reg(RegAcctMinWin,   CfgDataW'(mw));
    write_reg(RegRefresh,      CfgDataW'(rp));
    write_reg(RegMaxEntries,   CfgDataW'(me));
  endtask

  function automatic req_t make_req(logic [1:0] kind, logic [31:0] addr, logic [15:0] n);
    req_t r;
    r              = '0;
    r.req_type     = kind;
    r.ip_addr      = addr;
    r.credit_count = n;
    return r;
  endfunction

  // Random request: mostly ticks and acquires on a small pool of addresses
  function automatic req_t random_req();
    req_t r;
    int   pick;
    r.ip_addr        = 32'($urandom);
    r.credit_count   = 16'($urandom);
    r.sec_limit      = 16'($urandom);
    r.sec_window_s   = 8'($urandom);
    r.min_limit      = 16'($urandom);
    r.min_window_min = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) r.req_type = ReqTick;
    else if (pick < 58) r.req_type = ReqCreate;
    else if (pick < 95) r.req_type = ReqAcquire;
    else r.req_type = 2'd3;
    if ($urandom_range(9) < 8) r.ip_addr = 32'h0A00_0000 + 32'($urandom_range(19));
    if ($urandom_range(9) < 8) r.credit_count = 16'($urandom_range(12));
    if ($urandom_range(9) < 7) begin
      r.sec_limit      = 16'($urandom_range(40));
      r.min_limit      = 16'($urandom_range(120));
      r.sec_window_s   = ($urandom_range(3) == 0) ? 8'd1 : 8'd0;
      r.min_window_min = ($urandom_range(3) == 0) ? 8'd1 : 8'd0;
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_replies.size() != 0 || req_valid_i)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Sample the handshakes; predict on a request transfer, check on a reply transfer
  always @(posedge clk_i) begin
    rsp_t want;
    cycles <= cycles + 1;
    req_taken <= rst_ni && req_valid_i && !req_stall_o;
    if (rst_ni && req_valid_i && !req_stall_o)
      expected_replies.push_back(limiter_reply(req_i));
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected reply", 1, 0);
      end else begin
        want = expected_replies.pop_front();
        if (rsp_o.reply_kind !== want.reply_kind)
          report_mismatch("reply_kind", rsp_o.reply_kind, want.reply_kind);
        if (rsp_o.account_granted !== want.account_granted)
          report_mismatch("account_granted", rsp_o.account_granted, want.account_granted);
        if (rsp_o.addr_granted !== want.addr_granted)
          report_mismatch("addr_granted", rsp_o.addr_granted, want.addr_granted);
        if (rsp_o.create_status !== want.create_status)
          report_mismatch("create_status", rsp_o.create_status, want.create_status);
      end
    end
  end

  // Drive requests and stalls on the falling edge; hold a stalled transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_valid_i || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_i       <= pending_reqs.pop_front();
          req_valid_i <= 1'b1;
        end else begin
          req_valid_i <= 1'b0;
        end
      end
      rsp_stall_i <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // Give up on a hung block
  always @(posedge clk_i) begin
    if (cycles > CyclesLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int idle_sets [4][2];
    int settings [5][6];
    req_t r;

    idle_sets = '{'{0, 0}, '{50, 0}, '{0, 50}, '{30, 30}};
    settings = '{
      '{7, 2, 30, 9, 3, 4},
      '{10, 5, 40, 20, 1, 16},
      '{65535, 0, 65535, 16777215, 0, 20},
      '{0, 16777215, 0, 0, 65535, 0},
      '{20, 3, 50, 12, 2, 16}};

    send_idle_pct = 0;
    rcv_stall_pct = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;

    // Reset values of the registers and the limiter
    acct_sec_lim = 16'd10;   acct_sec_win = 24'd1000;
    acct_min_lim = 16'd100;  acct_min_win = 24'd60000;
    refresh_period = 16'd1;  table_cap_reg = 5'd16;
    now_ms = '0; countdown = 16'd1;
    acct_sec_rem = 16'd10; acct_min_rem = 16'd100;
    acct_sec_last = '0; acct_min_last = '0;
    ent_used = 0;
    for (int i = 0; i < TableDepth; i++) ent_valid[i] = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset-state behaviour first, before any register write
    pending_reqs.push_back(make_req(ReqAcquire, 32'h0, 16'd0));      // zero credits
    pending_reqs.push_back(make_req(ReqAcquire, 32'hFFFF_FFFF, 16'd3)); // unknown address
    pending_reqs.push_back(make_req(ReqAcquire, 32'h1, 16'hFFFF));    // far too many
    pending_reqs.push_back(make_req(2'd3, 32'hFFFF_FFFF, 16'hFFFF)); // unknown kind
    pending_reqs.push_back(make_req(ReqTick, 32'h0, 16'd0));
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      apply_setting(settings[p][0], settings[p][1], settings[p][2],
                    settings[p][3], settings[p][4], settings[p][5]);
      send_idle_pct = idle_sets[p % 4][0];
      rcv_stall_pct = idle_sets[p % 4][1];
      if (p == 0) begin
        // Extremes of the create fields, a duplicate, then a full table
        r = make_req(ReqCreate, 32'h0, 16'hFFFF);
        pending_reqs.push_back(r);
        r = make_req(ReqCreate, 32'hFFFF_FFFF, 16'h0);
        r.sec_limit = 16'hFFFF; r.min_limit = 16'hFFFF;
        r.sec_window_s = 8'hFF; r.min_window_min = 8'hFF;
        pending_reqs.push_back(r);
        pending_reqs.push_back(r);                                    // exists
        r = make_req(ReqCreate, 32'h0A00_0000, 16'd0);
        r.sec_limit = 16'd5; r.min_limit = 16'd8;
        pending_reqs.push_back(r);
        r.ip_addr = 32'h0A00_0001;
        pending_reqs.push_back(r);
        r.ip_addr = 32'h0A00_0002;
        pending_reqs.push_back(r);                                    // full
        pending_reqs.push_back(make_req(ReqAcquire, 32'h0A00_0000, 16'd3));
        pending_reqs.push_back(make_req(ReqAcquire, 32'h0A00_0000, 16'd3)); // address short
        pending_reqs.push_back(make_req(ReqAcquire, 32'hFFFF_FFFF, 16'd7));
        pending_reqs.push_back(make_req(ReqAcquire, 32'h0, 16'd0));
        for (int t = 0; t < 6; t++) pending_reqs.push_back(make_req(ReqTick, '0, '0));
        pending_reqs.push_back(make_req(ReqAcquire, 32'h0A00_0000, 16'd5));
      end
      for (int k = 0; k < 88; k++) pending_reqs.push_back(random_req());
      wait_drained();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== two_level_windowed_rate_limiter.f =====
rtl/twrl_pkg.sv
rtl/twrl_win_unit.sv
rtl/twrl_table.sv
rtl/two_level_windowed_rate_limiter.sv
bench/tb_two_level_windowed_rate_limiter.sv
